// File: hw/rtl/cps_pkg.sv
// Package: state codes, register indexes, reset values and item types of the precharge sequencer.
package cps_pkg;

  // Timer width default (saturating since-reset and precharge timers)
  localparam int TIMER_BITS_DEF = 16;

  // Vehicle state codes
  localparam logic [2:0] ST_STARTUP     = 3'd0;
  localparam logic [2:0] ST_OPEN        = 3'd1;
  localparam logic [2:0] ST_CLOSED      = 3'd2;
  localparam logic [2:0] ST_PRECHARGING = 3'd3;
  localparam logic [2:0] ST_DONE        = 3'd4;
  localparam logic [2:0] ST_DRIVING     = 3'd5;
  localparam logic [2:0] ST_FAULT       = 3'd6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_HOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_TORQUE = 3'd3;

  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0]        RST_STARTUP_HOLD  = 16'd2500;
  localparam logic [15:0]        RST_PRECHARGE_MIN = 16'd5000;
  localparam logic signed [15:0] RST_DELTA_LIMIT   = 16'sd10;
  localparam logic [11:0]        RST_CLOSED_TORQUE = 12'd100;

  typedef struct packed {
    logic [15:0]        startup_hold_ms;
    logic [15:0]        precharge_min_ms;
    logic signed [15:0] delta_limit_volts;
    logic [11:0]        closed_torque;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        elapsed_ms;
    logic               imd_fault;
    logic               imd_latch;
    logic               bms_fault_latched;
    logic               sdc_closed;
    logic               final_contactor_closed;
    logic               high_side_closed;
    logic               drive_request;
    logic               stop_request;
    logic signed [15:0] volt_delta;
  } item_t;

  typedef struct packed {
    logic [2:0]  veh_state;
    logic        final_close_drive;
    logic        precharge_drive;
    logic        inv_enable;
    logic [11:0] torque_cmd;
    logic        bms_fault_out;
  } result_t;

endpackage

// File: hw/rtl/cps_cfg.sv
// Configuration register file of the precharge sequencer.
module cps_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cps_pkg::cfg_t                    cfg
);

  cps_pkg::cfg_t cfg_r;
  cps_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  // Decode the index; ignore writes beyond the register list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        cps_pkg::CFG_STARTUP_HOLD:  cfg_nxt.startup_hold_ms   = cfg_data;
        cps_pkg::CFG_PRECHARGE_MIN: cfg_nxt.precharge_min_ms  = cfg_data;
        cps_pkg::CFG_DELTA_LIMIT:   cfg_nxt.delta_limit_volts = cfg_data;
        cps_pkg::CFG_CLOSED_TORQUE: cfg_nxt.closed_torque     = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.startup_hold_ms   <= cps_pkg::RST_STARTUP_HOLD;
      cfg_r.precharge_min_ms  <= cps_pkg::RST_PRECHARGE_MIN;
      cfg_r.delta_limit_volts <= cps_pkg::RST_DELTA_LIMIT;
      cfg_r.closed_torque     <= cps_pkg::RST_CLOSED_TORQUE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/cps_eval.sv
// Next-state and drive evaluation for one item of the precharge sequencer.
module cps_eval #(
  parameter int TIMER_BITS = cps_pkg::TIMER_BITS_DEF
) (
  input  cps_pkg::item_t          item,
  input  cps_pkg::cfg_t           cfg,
  input  logic [2:0]              cur_state,
  input  logic [2:0]              tgt_state,
  input  logic [TIMER_BITS-1:0]   since_ms,
  input  logic [TIMER_BITS-1:0]   pre_ms,
  input  logic                    pre_run,
  input  logic                    en_hold,
  input  logic [11:0]             trq_hold,
  input  logic                    flt_hold,
  output logic [2:0]              cur_state_nxt,
  output logic [2:0]              tgt_state_nxt,
  output logic [TIMER_BITS-1:0]   since_ms_nxt,
  output logic [TIMER_BITS-1:0]   pre_ms_nxt,
  output logic                    pre_run_nxt,
  output logic                    en_hold_nxt,
  output logic [11:0]             trq_hold_nxt,
  output logic                    flt_hold_nxt,
  output cps_pkg::result_t        res
);

  // Sum width covers both the timer and the 16-bit fields it is compared to
  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int SW = CW + 1;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic [SW-1:0]         since_sum;
  logic [SW-1:0]         pre_sum;
  logic [TIMER_BITS-1:0] pre_new;
  logic                  fault;
  logic                  fin;
  logic                  pre;
  logic [2:0]            next;

  assign fault = item.imd_fault | item.imd_latch | item.bms_fault_latched;

  assign since_sum    = SW'(since_ms) + SW'(item.elapsed_ms);
  assign since_ms_nxt = (since_sum > SW'(TMAX)) ? TMAX : since_sum[TIMER_BITS-1:0];

  assign pre_sum = SW'(pre_ms) + SW'(item.elapsed_ms);
  // Clear on the first precharge item, accumulate afterwards
  assign pre_new = !pre_run ? '0 :
                   (pre_sum > SW'(TMAX)) ? TMAX : pre_sum[TIMER_BITS-1:0];

  always_comb begin
    next          = cur_state;
    tgt_state_nxt = tgt_state;
    pre_ms_nxt    = pre_ms;
    en_hold_nxt   = en_hold;
    trq_hold_nxt  = trq_hold;
    flt_hold_nxt  = flt_hold;
    fin           = 1'b0;
    pre           = 1'b0;
    pre_run_nxt   = pre_run;
    unique case (cur_state)
      cps_pkg::ST_STARTUP: begin
        en_hold_nxt = 1'b0;
        if (SW'(since_ms_nxt) > SW'(cfg.startup_hold_ms)) begin
          tgt_state_nxt = cps_pkg::ST_OPEN;
          next          = cps_pkg::ST_OPEN;
        end
      end
      cps_pkg::ST_OPEN: begin
        en_hold_nxt  = 1'b0;
        trq_hold_nxt = '0;
        if (fault) begin
          next = cps_pkg::ST_FAULT;
        end else if (item.sdc_closed) begin
          tgt_state_nxt = cps_pkg::ST_CLOSED;
          next          = cps_pkg::ST_CLOSED;
        end
      end
      cps_pkg::ST_CLOSED: begin
        en_hold_nxt  = 1'b1;
        trq_hold_nxt = cfg.closed_torque;
        if (fault) begin
          next = cps_pkg::ST_FAULT;
        end else if (!item.sdc_closed) begin
          tgt_state_nxt = cps_pkg::ST_OPEN;
          next          = cps_pkg::ST_OPEN;
        end else if (item.drive_request) begin
          tgt_state_nxt = cps_pkg::ST_DRIVING;
          next          = cps_pkg::ST_PRECHARGING;
        end
      end
      cps_pkg::ST_PRECHARGING: begin
        pre = 1'b1;
        if (fault) begin
          next = cps_pkg::ST_FAULT;
        end else if (!item.sdc_closed) begin
          tgt_state_nxt = cps_pkg::ST_OPEN;
          next          = cps_pkg::ST_OPEN;
        end else if (tgt_state == cps_pkg::ST_DRIVING) begin
          pre_run_nxt = 1'b1;
          pre_ms_nxt  = pre_new;
          if ((SW'(pre_new) > SW'(cfg.precharge_min_ms)) &&
              (item.volt_delta < cfg.delta_limit_volts)) begin
            next = cps_pkg::ST_DRIVING;
          end
        end else begin
          tgt_state_nxt = cps_pkg::ST_CLOSED;
          next          = cps_pkg::ST_CLOSED;
        end
      end
      cps_pkg::ST_DONE: begin
        fin = 1'b1;
        pre = 1'b1;
        if (fault) begin
          next = cps_pkg::ST_FAULT;
        end else if (!item.sdc_closed) begin
          tgt_state_nxt = cps_pkg::ST_OPEN;
          next          = cps_pkg::ST_OPEN;
        end else if (!item.final_contactor_closed || !item.high_side_closed) begin
          tgt_state_nxt = cps_pkg::ST_CLOSED;
          next          = cps_pkg::ST_CLOSED;
        end else if (item.drive_request) begin
          tgt_state_nxt = cps_pkg::ST_DRIVING;
          next          = cps_pkg::ST_DRIVING;
        end
      end
      cps_pkg::ST_DRIVING: begin
        fin = 1'b1;
        pre = 1'b1;
        if (fault) begin
          next = cps_pkg::ST_FAULT;
        end else if (!item.sdc_closed) begin
          tgt_state_nxt = cps_pkg::ST_OPEN;
          next          = cps_pkg::ST_OPEN;
        end else if (item.stop_request) begin
          tgt_state_nxt = cps_pkg::ST_DONE;
          next          = cps_pkg::ST_DONE;
        end
      end
      default: begin
        // hard fault, and the unused code 7 treated the same
        flt_hold_nxt = 1'b1;
        next         = cps_pkg::ST_FAULT;
      end
    endcase
    if (next != cps_pkg::ST_PRECHARGING) begin
      pre_run_nxt = 1'b0;
    end
  end

  assign cur_state_nxt = next;

  assign res.veh_state         = next;
  assign res.final_close_drive = fin;
  assign res.precharge_drive   = pre;
  assign res.inv_enable        = en_hold_nxt;
  assign res.torque_cmd        = trq_hold_nxt;
  assign res.bms_fault_out     = flt_hold_nxt;

endmodule

// File: hw/rtl/contactor_precharge_sequencer.sv
// Top level of the battery contactor and precharge sequencer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in_     | into      | in_valid / in_ready  | elapsed_ms, fault flags, buttons, volt_delta
//   out_    | out of    | out_valid / out_ready| state, drives, enable, torque, fault
//   cfg_    | into      | cfg_valid / cfg_ready| cfg_index (3 bits), cfg_data (16 bits)
//
// One item per cycle sustained while out_ready stays high. An item is taken into
// the input register, evaluated by the next-state logic and loaded into the
// result register. The state feedback loop runs through cps_eval and the state
// registers. Reset (rst_n low, synchronous) sets the state to startup, clears the
// timers, the held values, both valid flags and loads the register defaults.
// While out_ready is low the result register holds and the input register keeps
// one item; in_ready drops only when both are full. cfg_ready is always high.
module contactor_precharge_sequencer #(
  parameter int TIMER_BITS = cps_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     in_elapsed_ms,
  input  logic                            in_imd_fault,
  input  logic                            in_imd_latch,
  input  logic                            in_bms_fault_latched,
  input  logic                            in_sdc_closed,
  input  logic                            in_final_contactor_closed,
  input  logic                            in_high_side_closed,
  input  logic                            in_drive_request,
  input  logic                            in_stop_request,
  input  logic signed [15:0]              in_volt_delta,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_veh_state,
  output logic                            out_final_close_drive,
  output logic                            out_precharge_drive,
  output logic                            out_inv_enable,
  output logic [11:0]                     out_torque_cmd,
  output logic                            out_bms_fault_out,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cps_pkg::cfg_t    cfg;
  cps_pkg::item_t   item_r;
  cps_pkg::result_t res_r;
  cps_pkg::result_t res_nxt;

  logic in_valid_r;
  logic out_valid_r;
  logic advance;
  logic in_take;

  // sequencer state
  logic [2:0]            cur_state_r,  cur_state_nxt;
  logic [2:0]            tgt_state_r,  tgt_state_nxt;
  logic [TIMER_BITS-1:0] since_ms_r,   since_ms_nxt;
  logic [TIMER_BITS-1:0] pre_ms_r,     pre_ms_nxt;
  logic                  pre_run_r,    pre_run_nxt;
  logic                  en_hold_r,    en_hold_nxt;
  logic [11:0]           trq_hold_r,   trq_hold_nxt;
  logic                  flt_hold_r,   flt_hold_nxt;

  cps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the buffered item when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.elapsed_ms             <= in_elapsed_ms;
      item_r.imd_fault              <= in_imd_fault;
      item_r.imd_latch              <= in_imd_latch;
      item_r.bms_fault_latched      <= in_bms_fault_latched;
      item_r.sdc_closed             <= in_sdc_closed;
      item_r.final_contactor_closed <= in_final_contactor_closed;
      item_r.high_side_closed       <= in_high_side_closed;
      item_r.drive_request          <= in_drive_request;
      item_r.stop_request           <= in_stop_request;
      item_r.volt_delta             <= in_volt_delta;
    end
  end

  cps_eval #(
    .TIMER_BITS (TIMER_BITS)
  ) u_eval (
    .item          (item_r),
    .cfg           (cfg),
    .cur_state     (cur_state_r),
    .tgt_state     (tgt_state_r),
    .since_ms      (since_ms_r),
    .pre_ms        (pre_ms_r),
    .pre_run       (pre_run_r),
    .en_hold       (en_hold_r),
    .trq_hold      (trq_hold_r),
    .flt_hold      (flt_hold_r),
    .cur_state_nxt (cur_state_nxt),
    .tgt_state_nxt (tgt_state_nxt),
    .since_ms_nxt  (since_ms_nxt),
    .pre_ms_nxt    (pre_ms_nxt),
    .pre_run_nxt   (pre_run_nxt),
    .en_hold_nxt   (en_hold_nxt),
    .trq_hold_nxt  (trq_hold_nxt),
    .flt_hold_nxt  (flt_hold_nxt),
    .res           (res_nxt)
  );

  // Commit the sequencer state only when an item is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= cps_pkg::ST_STARTUP;
      tgt_state_r <= cps_pkg::ST_OPEN;
      since_ms_r  <= '0;
      pre_ms_r    <= '0;
      pre_run_r   <= 1'b0;
      en_hold_r   <= 1'b0;
      trq_hold_r  <= '0;
      flt_hold_r  <= 1'b0;
    end else if (advance) begin
      cur_state_r <= cur_state_nxt;
      tgt_state_r <= tgt_state_nxt;
      since_ms_r  <= since_ms_nxt;
      pre_ms_r    <= pre_ms_nxt;
      pre_run_r   <= pre_run_nxt;
      en_hold_r   <= en_hold_nxt;
      trq_hold_r  <= trq_hold_nxt;
      flt_hold_r  <= flt_hold_nxt;
    end
  end

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_veh_state         = res_r.veh_state;
  assign out_final_close_drive = res_r.final_close_drive;
  assign out_precharge_drive   = res_r.precharge_drive;
  assign out_inv_enable        = res_r.inv_enable;
  assign out_torque_cmd        = res_r.torque_cmd;
  assign out_bms_fault_out     = res_r.bms_fault_out;

endmodule

// File: hw/rtl/cps_checker.sv
// Port-level checks for the precharge sequencer, bound to the top level.
module cps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_veh_state,
  input logic        out_final_close_drive,
  input logic        out_precharge_drive,
  input logic        out_bms_fault_out
);

  // The battery fault line sticks once it has been raised
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bms_fault_out) |=> out_bms_fault_out)
    else $error("bms fault line dropped");

  // A raised fault line only comes with the hard fault state
  a_fault_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bms_fault_out) |-> (out_veh_state == cps_pkg::ST_FAULT))
    else $error("fault line without hard fault state");

  // The final contactor is never driven without the precharge path
  a_drive_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_close_drive) |-> out_precharge_drive)
    else $error("final contactor driven without precharge path");

  // The unused state code never shows
  a_no_code7: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_veh_state <= cps_pkg::ST_FAULT))
    else $error("unused state code on output");

  // A stalled result stays valid and keeps its state code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_veh_state)))
    else $error("stalled result changed");

endmodule

bind contactor_precharge_sequencer cps_checker u_cps_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_veh_state         (out_veh_state),
  .out_final_close_drive (out_final_close_drive),
  .out_precharge_drive   (out_precharge_drive),
  .out_bms_fault_out     (out_bms_fault_out)
);
